/* design/tdma_pkg.sv */
`default_nettype none

package tdma_pkg;

  // Ring depth default and fixed field widths.
  localparam int WINDOW_DEF    = 8;
  localparam int SAMPLE_W      = 16;
  localparam int RANGE_W       = 2;
  localparam int DB_W          = 14;
  localparam int DIR_W         = 2;

  // Reset values of the configuration registers.
  localparam logic [RANGE_W-1:0] RANGE_RESET = 2'd1;
  localparam logic [DB_W-1:0]    DB_RESET    = 14'd80;

  // Counts per g are 1 << (LSB_SHIFT_MAX - range_select).
  localparam int LSB_SHIFT_MAX = 14;
  localparam int SHIFT_W       = 4;

  // Milli-g scale applied to the sums.
  localparam int SCALE_MG      = 1000;
  localparam int SCALE_W       = 10;

  // Quotient bits resolved per divider cycle.
  localparam int DIV_STEP_BITS = 4;

  // Direction codes.
  localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
  localparam logic [DIR_W-1:0] DIR_POS  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_NEG  = 2'd2;

  // Register indexes, taken from paddr[2].
  localparam logic REG_RANGE    = 1'b0;
  localparam logic REG_DEADBAND = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } tdma_state_t;

endpackage

`default_nettype wire

/* design/tdma_div_lane.sv */
`default_nettype none

// Signed sum divided by the fill count, truncated toward zero.
// Restoring division on the magnitude, STEP_BITS quotient bits per cycle while run is high.
module tdma_div_lane #(
  parameter int SUM_W     = tdma_pkg::SAMPLE_W + $clog2(tdma_pkg::WINDOW_DEF),
  parameter int N_W       = $clog2(tdma_pkg::WINDOW_DEF + 1),
  parameter int STEP_BITS = tdma_pkg::DIV_STEP_BITS
) (
  input  wire                                  clk,
  input  wire                                  start,
  input  wire                                  run,
  input  wire  logic signed [SUM_W-1:0]        sum,
  input  wire  logic [N_W-1:0]                 divisor,
  output logic signed [tdma_pkg::SAMPLE_W-1:0] mean
);

  localparam int DW = ((SUM_W + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;

  logic [DW-1:0]    quo_r, quo_nxt;
  logic [N_W:0]     rem_r, rem_nxt;
  logic             neg_r;
  logic [SUM_W-1:0] mag;
  logic [tdma_pkg::SAMPLE_W-1:0] qlo;

  assign mag = sum[SUM_W-1] ? SUM_W'(~sum + SUM_W'(1)) : SUM_W'(sum);

  always_comb begin
    logic [DW-1:0] q;
    logic [N_W:0]  r;
    q = quo_r;
    r = rem_r;
    for (int k = 0; k < STEP_BITS; k++) begin
      r = {r[N_W-1:0], q[DW-1]};
      q = {q[DW-2:0], 1'b0};
      if (r >= {1'b0, divisor}) begin
        r    = r - {1'b0, divisor};
        q[0] = 1'b1;
      end
    end
    quo_nxt = q;
    rem_nxt = r;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= DW'(mag);
      rem_r <= '0;
      neg_r <= sum[SUM_W-1];
    end else if (run) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign qlo  = quo_r[tdma_pkg::SAMPLE_W-1:0];
  assign mean = neg_r ? $signed(tdma_pkg::SAMPLE_W'(~qlo + tdma_pkg::SAMPLE_W'(1)))
                      : $signed(qlo);

endmodule

`default_nettype wire

/* design/tilt_direction_moving_average_core.sv */
`default_nettype none

// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+-----------------------------------------
// in_       | slave     | tvalid / tready    | raw_x, raw_y, raw_z samples
// out_      | master    | tvalid / tready    | means and tilt direction codes
// cfg_      | APB slave | psel/penable/pready| range_select, deadband_mg
//
// A request passes from idle through the read, multiply, divide and done states to the
// result register, and the next request is taken only once the block is back in idle,
// so requests do not overlap; the divider loop, four quotient bits a cycle, takes most
// of that time and is stepped by one counter for all three lanes.
// Reset (rst_n low, synchronous) clears the ring pointer, fill count, running sums,
// output valid and the registers to their defaults; the ring memory itself is not
// cleared, since entries are only read after they are written.
// A new request is taken while a finished result waits in the output register;
// the block holds in its last state until that register is free.
module tilt_direction_moving_average_core #(
  parameter int WINDOW = tdma_pkg::WINDOW_DEF
) (
  input  wire         clk,
  input  wire         rst_n,

  input  wire         in_tvalid,
  output logic        in_tready,
  // [15:0] raw_x, [31:16] raw_y, [47:32] raw_z
  input  wire  [47:0] in_tdata,

  output logic        out_tvalid,
  input  wire         out_tready,
  // [15:0] mean_x, [31:16] mean_y, [47:32] mean_z, [49:48] vertical_dir,
  // [51:50] horizontal_dir, [55:52] zero
  output logic [55:0] out_tdata,

  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [2:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int SW    = tdma_pkg::SAMPLE_W;
  // Width of the running sums: WINDOW samples of 16 bits.
  localparam int SUM_W = SW + $clog2(WINDOW);
  // Fill count holds 0..WINDOW.
  localparam int N_W   = $clog2(WINDOW + 1);
  // Ring address.
  localparam int AW    = $clog2(WINDOW);
  localparam int DW    = ((SUM_W + tdma_pkg::DIV_STEP_BITS - 1) / tdma_pkg::DIV_STEP_BITS)
                         * tdma_pkg::DIV_STEP_BITS;
  localparam int STEPS = DW / tdma_pkg::DIV_STEP_BITS;
  localparam int CNT_W = $clog2(STEPS + 1);
  // Scaled sum S*1000 and the limit deadband*L*n.
  localparam int SCW   = SUM_W + tdma_pkg::SCALE_W + 1;
  localparam int LBW   = tdma_pkg::DB_W + N_W;
  localparam int LW    = LBW + tdma_pkg::LSB_SHIFT_MAX;
  localparam int CW    = ((SCW > LW) ? SCW : LW) + 1;
  localparam int MW    = 3 * SW;

  // Configuration registers.
  logic [tdma_pkg::RANGE_W-1:0] range_r;
  logic [tdma_pkg::DB_W-1:0]    db_r;
  logic                         cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_r <= tdma_pkg::RANGE_RESET;
      db_r    <= tdma_pkg::DB_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        tdma_pkg::REG_RANGE:    range_r <= cfg_pwdata[tdma_pkg::RANGE_W-1:0];
        tdma_pkg::REG_DEADBAND: db_r    <= cfg_pwdata[tdma_pkg::DB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      tdma_pkg::REG_RANGE:    cfg_prdata = 32'(range_r);
      tdma_pkg::REG_DEADBAND: cfg_prdata = 32'(db_r);
      default:                cfg_prdata = '0;
    endcase
  end

  // Sequencer.
  tdma_pkg::tdma_state_t state_r, state_nxt;
  logic             in_acc;
  logic             mem_we;
  logic             lane_start;
  logic             lane_run;
  logic             out_load;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_acc = in_tvalid & in_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tdma_pkg::ST_IDLE: if (in_acc) state_nxt = tdma_pkg::ST_READ;
      tdma_pkg::ST_READ: state_nxt = tdma_pkg::ST_MUL;
      tdma_pkg::ST_MUL:  state_nxt = tdma_pkg::ST_DIV;
      tdma_pkg::ST_DIV:  if (cnt_r == CNT_W'(1)) state_nxt = tdma_pkg::ST_DONE;
      tdma_pkg::ST_DONE: if (!out_tvalid || out_tready) state_nxt = tdma_pkg::ST_IDLE;
      default:           state_nxt = tdma_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    mem_we     = 1'b0;
    lane_start = 1'b0;
    lane_run   = 1'b0;
    out_load   = 1'b0;
    cnt_nxt    = cnt_r;
    case (state_r)
      tdma_pkg::ST_IDLE: in_tready = 1'b1;
      tdma_pkg::ST_READ: mem_we = 1'b1;
      tdma_pkg::ST_MUL: begin
        lane_start = 1'b1;
        cnt_nxt    = CNT_W'(STEPS);
      end
      tdma_pkg::ST_DIV: begin
        lane_run = 1'b1;
        cnt_nxt  = cnt_r - CNT_W'(1);
      end
      tdma_pkg::ST_DONE: out_load = !out_tvalid || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tdma_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Ring memory: one entry holds x, y and z of one sample. The entry at the write
  // slot is read when a request is accepted and overwritten in the following cycle, so
  // the evicted sample can be taken out of the running sums.
  logic [MW-1:0] ring_mem [WINDOW];
  logic [MW-1:0] rd_data_r;
  logic [MW-1:0] smp_r;
  logic [AW-1:0] slot_r, slot_nxt;
  logic [N_W-1:0] fill_r, fill_nxt;
  logic           full;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_data_r <= ring_mem[slot_r];
      smp_r     <= in_tdata;
    end
    if (mem_we) begin
      ring_mem[slot_r] <= smp_r;
    end
  end

  assign full = (fill_r == N_W'(WINDOW));

  // Running sums: add the new sample, drop the evicted one once the ring is full.
  logic signed [SUM_W-1:0] sum_x_r, sum_y_r, sum_z_r;
  logic signed [SUM_W-1:0] sum_x_nxt, sum_y_nxt, sum_z_nxt;
  logic signed [SW-1:0]    old_x, old_y, old_z;

  always_comb begin
    old_x     = full ? $signed(rd_data_r[SW-1:0])      : '0;
    old_y     = full ? $signed(rd_data_r[2*SW-1:SW])   : '0;
    old_z     = full ? $signed(rd_data_r[3*SW-1:2*SW]) : '0;
    sum_x_nxt = sum_x_r + SUM_W'($signed(smp_r[SW-1:0]))      - SUM_W'(old_x);
    sum_y_nxt = sum_y_r + SUM_W'($signed(smp_r[2*SW-1:SW]))   - SUM_W'(old_y);
    sum_z_nxt = sum_z_r + SUM_W'($signed(smp_r[3*SW-1:2*SW])) - SUM_W'(old_z);
    slot_nxt  = (slot_r == AW'(WINDOW - 1)) ? '0 : slot_r + AW'(1);
    fill_nxt  = full ? fill_r : fill_r + N_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r <= '0;
      sum_y_r <= '0;
      sum_z_r <= '0;
      slot_r  <= '0;
      fill_r  <= '0;
    end else if (mem_we) begin
      sum_x_r <= sum_x_nxt;
      sum_y_r <= sum_y_nxt;
      sum_z_r <= sum_z_nxt;
      slot_r  <= slot_nxt;
      fill_r  <= fill_nxt;
    end
  end

  // Deadband products, registered in the multiply state.
  logic signed [SCW-1:0] scl_x_r, scl_y_r;
  logic [LBW-1:0]        lim_base_r;

  always_ff @(posedge clk) begin
    if (lane_start) begin
      scl_x_r    <= SCW'(sum_x_r) * SCW'(tdma_pkg::SCALE_MG);
      scl_y_r    <= SCW'(sum_y_r) * SCW'(tdma_pkg::SCALE_MG);
      lim_base_r <= LBW'(db_r) * LBW'(fill_r);
    end
  end

  // The limit is deadband*n times the counts per g, a power of two.
  logic [LW-1:0]         lim;
  logic signed [CW-1:0]  lim_s, cmp_x, cmp_y;
  logic [tdma_pkg::DIR_W-1:0] vdir, hdir;

  always_comb begin
    lim   = LW'(lim_base_r) << (tdma_pkg::SHIFT_W'(tdma_pkg::LSB_SHIFT_MAX)
                                - tdma_pkg::SHIFT_W'(range_r));
    lim_s = $signed(CW'(lim));
    cmp_x = CW'(scl_x_r);
    cmp_y = CW'(scl_y_r);
    if (cmp_y > lim_s)       vdir = tdma_pkg::DIR_POS;
    else if (cmp_y < -lim_s) vdir = tdma_pkg::DIR_NEG;
    else                     vdir = tdma_pkg::DIR_NONE;
    if (cmp_x > lim_s)       hdir = tdma_pkg::DIR_POS;
    else if (cmp_x < -lim_s) hdir = tdma_pkg::DIR_NEG;
    else                     hdir = tdma_pkg::DIR_NONE;
  end

  // Three divider lanes share one step counter.
  logic signed [SW-1:0] mean_x, mean_y, mean_z;

  tdma_div_lane #(.SUM_W(SUM_W), .N_W(N_W), .STEP_BITS(tdma_pkg::DIV_STEP_BITS)) u_div_x (
    .clk(clk), .start(lane_start), .run(lane_run),
    .sum(sum_x_r), .divisor(fill_r), .mean(mean_x)
  );

  tdma_div_lane #(.SUM_W(SUM_W), .N_W(N_W), .STEP_BITS(tdma_pkg::DIV_STEP_BITS)) u_div_y (
    .clk(clk), .start(lane_start), .run(lane_run),
    .sum(sum_y_r), .divisor(fill_r), .mean(mean_y)
  );

  tdma_div_lane #(.SUM_W(SUM_W), .N_W(N_W), .STEP_BITS(tdma_pkg::DIV_STEP_BITS)) u_div_z (
    .clk(clk), .start(lane_start), .run(lane_run),
    .sum(sum_z_r), .divisor(fill_r), .mean(mean_z)
  );

  // Output register, which decouples the result from the next request.
  logic        out_valid_r, out_valid_nxt;
  logic [55:0] out_data_r;

  assign out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {4'b0000, hdir, vdir, mean_z, mean_y, mean_x};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

/* tb/testbench.sv */
module testbench;

  // Ring depth under test, the watchdog limit in quiet cycles, and the number of
  // cycles let pass after the last result.
  localparam int RING_DEPTH   = 8;
  localparam int QUIET_LIMIT  = 4000;
  localparam int SETTLE_WAIT  = 12;
  localparam int FINAL_WAIT   = 24;
  localparam int PHASES       = 12;
  localparam int GROUPS       = 13;

  // Stimulus flavors. Each group of RING_DEPTH requests shares one flavor, so a
  // whole window can sit right at the deadband edge or at full scale.
  localparam int FLAVOR_ANY   = 0;
  localparam int FLAVOR_EDGE  = 1;
  localparam int FLAVOR_RAIL  = 2;
  localparam int FLAVOR_SMALL = 3;

  // Idling modes, used in this order over the run.
  localparam int IDLE_SENDER_LIGHT = 0;
  localparam int IDLE_SENDER_HEAVY = 1;
  localparam int IDLE_NONE         = 2;

  typedef struct {
    logic signed [15:0]           mean_x;
    logic signed [15:0]           mean_y;
    logic signed [15:0]           mean_z;
    logic [tdma_pkg::DIR_W-1:0]   vertical;
    logic [tdma_pkg::DIR_W-1:0]   horizontal;
  } tilt_result_t;

  // The register settings walked through after the directed part. They include
  // both range extremes, a zero deadband, the largest 14-bit deadband, and a
  // deadband of 125 mg, which at 4g lands exactly on a whole count (1024).
  int unsigned range_plan [PHASES] = '{0, 3, 2, 1, 0, 3, 1, 2, 0, 3, 1, 2};
  int unsigned db_plan    [PHASES] = '{0, 16383, 16000, 125, 1, 0, 80, 250, 16383, 40, 125, 1};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_tvalid = 1'b0;
  wire         in_tready;
  logic [47:0] in_tdata = '0;

  wire         out_tvalid;
  logic        out_tready = 1'b0;
  wire  [55:0] out_tdata;

  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  wire  [31:0] cfg_prdata;
  wire         cfg_pready;

  tilt_direction_moving_average_core #(
    .WINDOW(RING_DEPTH)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the block: the three sample rings, the next slot to write,
  // the fill count and the two registers as last written.
  logic signed [15:0] ring_x [RING_DEPTH];
  logic signed [15:0] ring_y [RING_DEPTH];
  logic signed [15:0] ring_z [RING_DEPTH];
  logic [2:0]         next_slot = '0;
  int                 held = 0;
  logic [tdma_pkg::RANGE_W-1:0] range_cfg = tdma_pkg::RANGE_RESET;
  logic [tdma_pkg::DB_W-1:0]    db_cfg = tdma_pkg::DB_RESET;

  // Requests waiting to be driven, and the results the block still owes us.
  logic [47:0]  pending_samples [$];
  tilt_result_t expected_means [$];

  int samples_queued = 0;
  int samples_sent = 0;
  int results_seen = 0;
  int reg_writes = 0;
  int errors = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // The direction is decided on the exact mean: sum * 1000 against
  // deadband * counts-per-g * fill count, so no division is involved.
  function automatic logic [tdma_pkg::DIR_W-1:0] tilt_dir(longint sum, longint limit);
    if (sum * tdma_pkg::SCALE_MG > limit) return tdma_pkg::DIR_POS;
    if (sum * tdma_pkg::SCALE_MG < -limit) return tdma_pkg::DIR_NEG;
    return tdma_pkg::DIR_NONE;
  endfunction

  // Stores one sample triple in the shadow rings and works out the means and
  // direction codes that the block must return for it.
  function automatic tilt_result_t average_sample(logic [47:0] d);
    tilt_result_t r;
    longint sx, sy, sz, limit;
    ring_x[next_slot] = d[15:0];
    ring_y[next_slot] = d[31:16];
    ring_z[next_slot] = d[47:32];
    next_slot = next_slot + 3'd1;
    if (held < RING_DEPTH) held++;
    sx = 0;
    sy = 0;
    sz = 0;
    // Only slots 0..held-1 take part; before the ring is full they are exactly
    // the ones written so far.
    for (int i = 0; i < held; i++) begin
      sx += ring_x[i];
      sy += ring_y[i];
      sz += ring_z[i];
    end
    // Signed division in SystemVerilog truncates toward zero, as required.
    r.mean_x = 16'(sx / held);
    r.mean_y = 16'(sy / held);
    r.mean_z = 16'(sz / held);
    limit = longint'(db_cfg) * longint'(16384 >> range_cfg) * held;
    r.vertical   = tilt_dir(sy, limit);
    r.horizontal = tilt_dir(sx, limit);
    return r;
  endfunction

  // One axis sample of the given flavor. The edge flavor sits within three
  // counts of the deadband, in counts, on either side of zero.
  function automatic logic [15:0] pick_sample(int flavor, int edge_counts);
    int v;
    case (flavor)
      FLAVOR_EDGE: begin
        v = edge_counts + int'($urandom_range(0, 6)) - 3;
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      FLAVOR_RAIL: begin
        case ($urandom_range(0, 3))
          0:       v = -32768;
          1:       v = 32767;
          2:       v = -1;
          default: v = 1;
        endcase
      end
      FLAVOR_SMALL: v = int'($urandom_range(0, 4095)) - 2048;
      default:      v = int'($urandom_range(0, 65535)) - 32768;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  task automatic queue_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    pending_samples.push_back({z, y, x});
    samples_queued++;
  endtask

  task automatic set_idling(int mode);
    case (mode)
      IDLE_SENDER_LIGHT: begin
        send_idle_pct = 36;
        recv_idle_pct = 60;
      end
      IDLE_SENDER_HEAVY: begin
        send_idle_pct = 60;
        recv_idle_pct = 36;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  // APB write: setup cycle, then access cycle until pready is seen high.
  task automatic write_reg(logic reg_sel, logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_sel, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    reg_writes++;
  endtask

  // APB read with a check of the returned value against the shadow copy.
  task automatic read_reg(logic reg_sel, logic [31:0] want);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {reg_sel, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== want) begin
      errors++;
      $display("%0t: register %0d read back, expected %0d, got %0d",
               $time, reg_sel, want, cfg_prdata);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Waits until every queued request has produced its result, then lets the
  // block settle so that a register write never lands on work in flight.
  task automatic drain();
    while (results_seen < samples_queued) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Request driver. A request stays on the bus until taken; the next one is
  // offered right behind it unless the sender decides to idle this cycle.
  // The expectation is computed at the edge that accepts the request, so the
  // shadow registers in force at that moment are the ones used.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_means.push_back(average_sample(in_tdata));
        samples_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_tdata  <= pending_samples.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Back-pressure is random per cycle; every accepted result
  // is compared field by field against the oldest expectation.
  always @(posedge clk) begin : result_monitor
    tilt_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_means.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, expected none, got %h",
                   $time, out_tdata);
        end else begin
          want = expected_means.pop_front();
          check_field("mean_x", want.mean_x, $signed(out_tdata[15:0]));
          check_field("mean_y", want.mean_y, $signed(out_tdata[31:16]));
          check_field("mean_z", want.mean_z, $signed(out_tdata[47:32]));
          check_field("vertical_dir", want.vertical, out_tdata[49:48]);
          check_field("horizontal_dir", want.horizontal, out_tdata[51:50]);
          check_field("padding", 0, out_tdata[55:52]);
        end
      end
    end
  end

  // Watchdog: any request, result or register access resets the quiet count.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int edge_counts;
    int flavor;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, run at the reset register values (4g, 80 mg, so the
    // deadband is about 655 counts). It covers the partial ring, full-scale
    // samples of both signs, the ring filling up and wrapping, a complete
    // overwrite of the window, and samples just inside and outside the deadband.
    set_idling(IDLE_SENDER_LIGHT);
    queue_sample(16'sd0, 16'sd0, 16'sd0);
    queue_sample(16'sd32767, -16'sd32768, 16'sd32767);
    queue_sample(-16'sd32768, 16'sd32767, -16'sd32768);
    repeat (7) queue_sample(16'sd32767, 16'sd32767, 16'sd32767);
    repeat (8) queue_sample(-16'sd32768, -16'sd32768, -16'sd32768);
    queue_sample(16'sd655, -16'sd655, 16'sd3);
    queue_sample(16'sd656, -16'sd656, -16'sd3);
    queue_sample(-16'sd1, 16'sd1, 16'h5555);
    queue_sample(16'hAAAA, 16'h5555, 16'hAAAA);
    drain();

    // Random part: each phase rewrites both registers while the block is idle,
    // reads them back, and then sends groups of well-formed windows.
    for (int p = 0; p < PHASES; p++) begin
      set_idling(p / 4);
      write_reg(tdma_pkg::REG_RANGE, range_plan[p]);
      range_cfg = range_plan[p];
      write_reg(tdma_pkg::REG_DEADBAND, db_plan[p]);
      db_cfg = db_plan[p];
      read_reg(tdma_pkg::REG_RANGE, 32'(range_cfg));
      read_reg(tdma_pkg::REG_DEADBAND, 32'(db_cfg));
      edge_counts = int'(db_cfg) * (16384 >> range_cfg) / tdma_pkg::SCALE_MG;
      for (int g = 0; g < GROUPS; g++) begin
        flavor = $urandom_range(FLAVOR_ANY, FLAVOR_SMALL);
        for (int k = 0; k < RING_DEPTH; k++)
          queue_sample(pick_sample(flavor, edge_counts), pick_sample(flavor, edge_counts),
                       pick_sample(flavor, edge_counts));
      end
      drain();
    end

    repeat (FINAL_WAIT) @(posedge clk);
    $display("Sent %0d sample requests and checked %0d results over %0d register settings.",
             samples_sent, results_seen, PHASES + 1);
    $display("Made %0d register writes; idling went sender-light, sender-heavy, then none.",
             reg_writes);
    if (errors == 0 && expected_means.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived", errors, expected_means.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/tdma_pkg.sv
design/tdma_div_lane.sv
design/tilt_direction_moving_average_core.sv
tb/testbench.sv
